### src/bis_pkg.sv
// Shared types, constants and state codes of the bicubic image scaler.
package bis_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int COORD_W = 12;
   localparam int IDX_W   = 13;
   localparam int SCALE_W = 13;
   localparam int DIM_W   = 9;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int QUOT_W  = COORD_W + 16;
   localparam int WGT_W   = 17;
   localparam int CSR_AW  = 2;

   localparam logic [CSR_AW-1:0] REG_SCALE_Q8   = 2'd0;
   localparam logic [CSR_AW-1:0] REG_SRC_WIDTH  = 2'd1;
   localparam logic [CSR_AW-1:0] REG_SRC_HEIGHT = 2'd2;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   typedef struct packed {
      logic                 op;
      logic                 in_store;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic [PIX_W-1:0]     pix;
   } cmd_type;

   typedef struct packed {
      logic                 we;
      logic [CSR_AW-1:0]    addr;
      logic [SCALE_W-1:0]   wdata;
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_CHECK,
      ST_DIV,
      ST_WEIGHT,
      ST_ACC,
      ST_ROUND,
      ST_DONE
   } back_state_type;

endpackage

### src/bis_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bis_front.sv
// Front end: takes input beats, classifies loads and queues commands for the back end.
module bis_front import bis_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        in_op,
   input  logic [47:0] in_data,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_pop
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   cmd_type     new_cmd;

   always_comb begin
      new_cmd.op  = in_op;
      new_cmd.col = in_data[COORD_W-1:0];
      new_cmd.row = in_data[2*COORD_W-1:COORD_W];
      new_cmd.pix = in_data[2*COORD_W+PIX_W-1:2*COORD_W];
      // Loads that fall outside the store are marked here and dropped later.
      new_cmd.in_store = ({1'b0, new_cmd.col} < IDX_W'(MAX_WIDTH)) &&
                         ({1'b0, new_cmd.row} < IDX_W'(MAX_HEIGHT));
   end

   assign in_ready  = (count_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### src/bis_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bis_div import bis_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [QUOT_W-1:0]  dividend,
   input  logic [SCALE_W-1:0] divisor,
   output logic               done,
   output logic [QUOT_W-1:0]  quotient
);

   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [SCALE_W-1:0] rem_ff, rem_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SCALE_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, quot_ff[QUOT_W-1]};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = 5'(QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in  = SCALE_W'(trial - {1'b0, divisor});
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[SCALE_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### src/bis_back.sv
// Back end: register file, frame-store sequencing, kernel weights and accumulation.
module bis_back import bis_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  csr_type            csr,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [PIX_W-1:0]   out_data,
   output logic               out_oor
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = 34;
   localparam int PW    = 2 * WGT_W;
   localparam int AccW  = 46;

   back_state_type state_ff, state_in;

   logic [SCALE_W-1:0] scale_ff;
   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [SCALE_W-1:0] sc_sat;
   logic [IDX_W-1:0]   w_sat, h_sat;

   logic [COORD_W-1:0] col_ff, row_ff;
   logic [17:0]        lim_w_ff, lim_h_ff;

   logic               div_start;
   logic               div_x_done, div_y_done;
   logic [QUOT_W-1:0]  qx, qy;
   logic               xdone_ff, ydone_ff;
   logic [IDX_W-1:0]   x1, y1;
   logic [7:0]         dx, dy;

   logic [3:0]         issue_ff, issue_in;
   logic [9:0]         t_p0_ff;
   logic [2:0]         tag_p0_ff, tag_p1_ff, tag_p2_ff;
   logic               v_p0_ff, v_p1_ff, v_p2_ff;
   logic [9:0]         t_p1_ff, t_p2_ff;
   logic [18:0]        sq_p1_ff, sq_p2_ff;
   logic [27:0]        cube_p2_ff;
   logic [9:0]         t_issue;
   logic [7:0]         d_issue;
   logic signed [KW-1:0]    c_s, s_s, t_s, v_k, v_r;
   logic signed [WGT_W-1:0] w_new;
   logic signed [WGT_W-1:0] wx_ff [4];
   logic signed [WGT_W-1:0] wy_ff [4];

   logic [4:0]         step_ff, step_in;
   logic               acc_v_ff;
   logic signed [PW-1:0]   wt_ff;
   logic signed [AccW-1:0] acc_ff [3];
   logic [IDX_W-1:0]   xx, yy;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [PIX_W-1:0]   ram_rdata;

   logic [PIX_W-1:0]   res_ff;
   logic               res_oor_ff;
   logic               out_valid_ff;
   logic [PIX_W-1:0]   out_data_ff;
   logic               out_oor_ff;
   logic               out_load;

   function automatic logic [IDX_W-1:0] clamp_idx(logic [IDX_W-1:0] base, logic [1:0] off,
                                                  logic [IDX_W-1:0] lim);
      logic [IDX_W:0] v;
      v = {1'b0, base} + (IDX_W+1)'(off);
      if (v == '0) begin
         return '0;
      end
      v = v - (IDX_W+1)'(1);
      if (v > {1'b0, lim - IDX_W'(1)}) begin
         return lim - IDX_W'(1);
      end
      return v[IDX_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] round_chan(logic signed [AccW-1:0] s);
      logic signed [AccW-1:0] r;
      r = (s + AccW'(64'sd134217728)) >>> 28;
      if (s < 0) begin
         return '0;
      end
      if (r > AccW'(255)) begin
         return 8'hFF;
      end
      return r[CHAN_W-1:0];
   endfunction

   // Registers hold what was written, sizes cut to DIM_W bits; saturated on use.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_W'(256);
         width_ff  <= DIM_W'(256);
         height_ff <= DIM_W'(256);
      end else if (csr.we) begin
         case (csr.addr)
            REG_SCALE_Q8:   scale_ff  <= csr.wdata;
            REG_SRC_WIDTH:  width_ff  <= csr.wdata[DIM_W-1:0];
            REG_SRC_HEIGHT: height_ff <= csr.wdata[DIM_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      sc_sat = scale_ff;
      if (scale_ff < SCALE_W'(16)) begin
         sc_sat = SCALE_W'(16);
      end else if (scale_ff > SCALE_W'(4096)) begin
         sc_sat = SCALE_W'(4096);
      end
      w_sat = IDX_W'(width_ff);
      if (width_ff == '0) begin
         w_sat = IDX_W'(1);
      end else if (IDX_W'(width_ff) > IDX_W'(MAX_WIDTH)) begin
         w_sat = IDX_W'(MAX_WIDTH);
      end
      h_sat = IDX_W'(height_ff);
      if (height_ff == '0) begin
         h_sat = IDX_W'(1);
      end else if (IDX_W'(height_ff) > IDX_W'(MAX_HEIGHT)) begin
         h_sat = IDX_W'(MAX_HEIGHT);
      end
   end

   bis_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({col_ff, 16'd0}),
      .divisor  (sc_sat),
      .done     (div_x_done),
      .quotient (qx)
   );

   bis_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({row_ff, 16'd0}),
      .divisor  (sc_sat),
      .done     (div_y_done),
      .quotient (qy)
   );

   assign x1 = qx[8 +: IDX_W];
   assign y1 = qy[8 +: IDX_W];
   assign dx = qx[7:0];
   assign dy = qy[7:0];

   // Kernel argument for tap i is |(i-1)*256 - d|; taps 0..3 are columns, 4..7 rows.
   always_comb begin
      d_issue = issue_ff[2] ? dy : dx;
      case (issue_ff[1:0])
         2'd0:    t_issue = 10'd256 + 10'(d_issue);
         2'd1:    t_issue = 10'(d_issue);
         2'd2:    t_issue = 10'd256 - 10'(d_issue);
         default: t_issue = 10'd512 - 10'(d_issue);
      endcase
   end

   always_comb begin
      c_s = $signed({6'd0, cube_p2_ff});
      s_s = $signed({15'd0, sq_p2_ff});
      t_s = $signed({24'd0, t_p2_ff});
      if (t_p2_ff <= 10'd256) begin
         v_k = KW'(3) * c_s - KW'(1280) * s_s + KW'(34'sd33554432);
      end else begin
         v_k = KW'(1280) * s_s - c_s - (t_s <<< 19) + KW'(34'sd67108864);
      end
      v_r = (v_k + KW'(1024)) >>> 11;
      w_new = (t_p2_ff < 10'd512) ? v_r[WGT_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p0_ff <= 1'b0;
         v_p1_ff <= 1'b0;
         v_p2_ff <= 1'b0;
      end else begin
         v_p0_ff <= (state_ff == ST_WEIGHT) && !issue_ff[3];
         v_p1_ff <= v_p0_ff;
         v_p2_ff <= v_p1_ff;
      end
      t_p0_ff    <= t_issue;
      tag_p0_ff  <= issue_ff[2:0];
      t_p1_ff    <= t_p0_ff;
      tag_p1_ff  <= tag_p0_ff;
      sq_p1_ff   <= 19'({9'd0, t_p0_ff} * {9'd0, t_p0_ff});
      t_p2_ff    <= t_p1_ff;
      tag_p2_ff  <= tag_p1_ff;
      sq_p2_ff   <= sq_p1_ff;
      cube_p2_ff <= 28'({18'd0, t_p1_ff} * {9'd0, sq_p1_ff});
      if (v_p2_ff) begin
         if (tag_p2_ff[2]) begin
            wy_ff[tag_p2_ff[1:0]] <= w_new;
         end else begin
            wx_ff[tag_p2_ff[1:0]] <= w_new;
         end
      end
   end

   // Neighbour taps in raster order: step bits 1:0 pick the column, 3:2 the row.
   always_comb begin
      xx = clamp_idx(x1, step_ff[1:0], w_sat);
      yy = clamp_idx(y1, step_ff[3:2], h_sat);
      ram_raddr = AW'(yy * MAX_WIDTH + xx);
      ram_waddr = AW'(cmd.row * MAX_WIDTH + cmd.col);
   end

   always_ff @(posedge clock) begin
      wt_ff <= PW'(wx_ff[step_ff[1:0]]) * PW'(wy_ff[step_ff[3:2]]);
      if (state_ff == ST_LIMIT) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= '0;
         end
      end else if (acc_v_ff) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_ff[c] + AccW'(wt_ff) *
                         AccW'($signed({1'b0, ram_rdata[c*CHAN_W +: CHAN_W]}));
         end
      end
   end

   bis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd.pix),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      cmd_pop   = 1'b0;
      ram_we    = 1'b0;
      div_start = 1'b0;
      issue_in  = issue_ff;
      step_in   = step_ff;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == OP_LOAD) begin
                  ram_we = cmd.in_store;
               end else begin
                  state_in = ST_LIMIT;
               end
            end
         end
         ST_LIMIT: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ({6'd0, col_ff} >= lim_w_ff || {6'd0, row_ff} >= lim_h_ff) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if ((xdone_ff || div_x_done) && (ydone_ff || div_y_done)) begin
               issue_in = '0;
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            if (!issue_ff[3]) begin
               issue_in = issue_ff + 4'd1;
            end
            if (v_p2_ff && tag_p2_ff == 3'd7) begin
               step_in  = '0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (step_ff == 5'd16) begin
               state_in = ST_ROUND;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_ROUND: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || out_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         acc_v_ff     <= 1'b0;
         xdone_ff     <= 1'b0;
         ydone_ff     <= 1'b0;
         issue_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff <= state_in;
         acc_v_ff <= (state_ff == ST_ACC) && (step_ff != 5'd16);
         issue_ff <= issue_in;
         step_ff  <= step_in;
         if (div_start) begin
            xdone_ff <= 1'b0;
            ydone_ff <= 1'b0;
         end else begin
            xdone_ff <= xdone_ff || div_x_done;
            ydone_ff <= ydone_ff || div_y_done;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (state_ff == ST_IDLE && cmd_valid) begin
         col_ff <= cmd.col;
         row_ff <= cmd.row;
      end
      if (state_ff == ST_LIMIT) begin
         lim_w_ff <= 18'(({13'd0, w_sat} * {13'd0, sc_sat}) >> 8);
         lim_h_ff <= 18'(({13'd0, h_sat} * {13'd0, sc_sat}) >> 8);
      end
      if (state_ff == ST_CHECK) begin
         res_ff     <= '0;
         res_oor_ff <= 1'b1;
      end else if (state_ff == ST_ROUND) begin
         res_ff     <= {round_chan(acc_ff[2]), round_chan(acc_ff[1]), round_chan(acc_ff[0])};
         res_oor_ff <= 1'b0;
      end
      if (out_load) begin
         out_data_ff <= res_ff;
         out_oor_ff  <= res_oor_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_oor   = out_oor_ff;

   a_store_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("frame store written outside idle");

   a_taps_in_image: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WEIGHT) |-> (x1 < w_sat) && (y1 < h_sat))
      else $error("source position outside the image");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> step_ff <= 5'd16)
      else $error("accumulation step overrun");

   a_acc_in_acc: assert property (@(posedge clock) disable iff (reset)
      acc_v_ff |-> (state_ff == ST_ACC) && $past(state_ff == ST_ACC))
      else $error("accumulation outside the accumulate phase");

endmodule

### src/bicubic_image_scaler_top.sv
// Top level of the bicubic image scaler.
// Bicubic (Keys, a = -1/2) image scaler over a MAX_WIDTH x MAX_HEIGHT frame store of BGR
// pixels. A load beat writes one pixel, unless it falls outside the store, without leaving
// the idle state of the back end. A compute beat checks the coordinate against the scaled
// size, maps it to source space in the two bit-serial dividers, runs the three-stage
// kernel weight pipeline for the eight taps, reads the sixteen neighbours from the frame
// store through the single read port while accumulating, and then rounds and presents the
// result. Out-of-range computes skip the divider, weight and accumulation steps. A two-entry
// command queue parts input from processing, and an output register holds the result
// beat. The frame store is not cleared; pixels must be loaded before they are read.
module bicubic_image_scaler_top import bis_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,  // col, row, blue_in, green_in, red_in
   input  logic               req_tuser,  // op
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,  // blue_out, green_out, red_out
   output logic               rsp_tuser,  // out_of_range
   input  logic               csr_we,
   input  logic [CSR_AW-1:0]  csr_addr,
   input  logic [SCALE_W-1:0] csr_wdata
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   csr_type csr;

   assign csr.we    = csr_we;
   assign csr.addr  = csr_addr;
   assign csr.wdata = csr_wdata;

   bis_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_data   (req_tdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   bis_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_oor   (rsp_tuser)
   );

endmodule
